/* src/nptt_pkg.sv */
`default_nettype none

package nptt_pkg;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_FIND_STA = 2'd2,
    ACT_FIND_PUB = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic [31:0] sta_ip;
    logic [15:0] sta_port;
    logic [15:0] public_port;
  } entry_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic        match_en;
    logic        key_sel;
    logic [15:0] key;
    logic        apply;
    action_t     op;
    entry_t      new_entry;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* src/nptt_if.sv */
`default_nettype none

interface nptt_in_if;
  import nptt_pkg::*;

  logic        valid;
  logic        ready;
  action_t     action;
  logic [31:0] sta_ip;
  logic [15:0] sta_port;
  logic [15:0] public_port;

  modport source (output valid, action, sta_ip, sta_port, public_port, input ready);
  modport sink (input valid, action, sta_ip, sta_port, public_port, output ready);
endinterface

interface nptt_out_if;
  import nptt_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] found_sta_ip;
  logic [15:0] found_sta_port;
  logic [15:0] found_public_port;

  modport source (
    output valid, status, found_sta_ip, found_sta_port, found_public_port,
    input ready
  );
  modport sink (
    input valid, status, found_sta_ip, found_sta_port, found_public_port,
    output ready
  );
endinterface

`default_nettype wire

/* src/nptt_cell.sv */
`default_nettype none

module nptt_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  nptt_pkg::cell_cmd_t  cmd,
  input  wire                  prev_valid,
  input  wire                  hit_in,
  input  nptt_pkg::entry_t     acc_in,
  input  nptt_pkg::entry_t     next_entry,
  input  wire                  next_valid,
  output logic                 valid_o,
  output nptt_pkg::entry_t     entry_o,
  output logic                 hit_o,
  output nptt_pkg::entry_t     acc_o
);
  import nptt_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  entry_t entry_r;
  entry_t entry_nxt;
  logic   match_r;
  logic   first;
  logic   [15:0] cmp_field;

  assign cmp_field = cmd.key_sel ? entry_r.sta_port : entry_r.public_port;

  // The oldest matching cell is the first one with no hit to its left.
  assign first   = match_r & ~hit_in;
  assign hit_o   = hit_in | match_r;
  assign acc_o   = first ? (acc_in | entry_r) : acc_in;
  assign valid_o = valid_r;
  assign entry_o = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (cmd.apply) begin
      case (cmd.op)
        ACT_ADD: begin
          if (!valid_r && prev_valid) begin
            valid_nxt = 1'b1;
            entry_nxt = cmd.new_entry;
          end
        end
        ACT_REMOVE: begin
          // Every cell from the removed one onwards takes its right neighbour.
          if (hit_o) begin
            valid_nxt = next_valid;
            entry_nxt = next_entry;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.match_en) begin
        match_r <= valid_r && (cmp_field == cmd.key);
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

/* src/nat_port_translation_table.sv */
// Channel  Dir  Handshake      Beat contents
// in_bus   in   valid / ready  action, sta_ip, sta_port, public_port
// out_bus  out  valid / ready  status, found_sta_ip, found_sta_port, found_public_port
//
// The row of cells compares each beat's key in the accept cycle and registers
// the match; the oldest hit is resolved along the cell chain in ST_RESOLVE.
// Reset (rst_n low, synchronous) empties the table and the output register.
// A result waits in the output register while the next beat is accepted; the
// resolve cycle stalls only while that register is still full and not taken.
`default_nettype none

module nat_port_translation_table #(
  parameter int ENTRIES = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  nptt_in_if.sink    in_bus,
  nptt_out_if.source out_bus
);
  import nptt_pkg::*;

  state_t    state_r;
  state_t    state_nxt;
  action_t   op_r;
  entry_t    item_r;
  cell_cmd_t cmd;
  logic      in_fire;
  logic      out_free;
  logic      commit;

  logic      out_valid_r;
  status_t   status_r;
  entry_t    res_r;
  status_t   status_nxt;
  entry_t    res_nxt;

  logic   [ENTRIES-1:0] vld;
  entry_t               ent [ENTRIES];
  logic   [ENTRIES:0]   hit;
  entry_t               acc [ENTRIES+1];

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_RESOLVE;
      ST_RESOLVE: if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready = 1'b0;
    commit       = 1'b0;
    case (state_r)
      ST_IDLE:    in_bus.ready = 1'b1;
      ST_RESOLVE: commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r               <= in_bus.action;
      item_r.sta_ip      <= in_bus.sta_ip;
      item_r.sta_port    <= in_bus.sta_port;
      item_r.public_port <= in_bus.public_port;
    end
  end

  always_comb begin
    cmd.match_en  = in_fire;
    cmd.key_sel   = (in_bus.action == ACT_FIND_PUB);
    cmd.key       = cmd.key_sel ? in_bus.sta_port : in_bus.public_port;
    cmd.apply     = commit;
    cmd.op        = op_r;
    cmd.new_entry = item_r;
  end

  assign hit[0] = 1'b0;
  assign acc[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic   prev_v;
    logic   next_v;
    entry_t next_e;

    if (g == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = vld[g-1];
    end

    if (g == ENTRIES - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_e = '0;
    end else begin : g_inner
      assign next_v = vld[g+1];
      assign next_e = ent[g+1];
    end

    nptt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (prev_v),
      .hit_in     (hit[g]),
      .acc_in     (acc[g]),
      .next_entry (next_e),
      .next_valid (next_v),
      .valid_o    (vld[g]),
      .entry_o    (ent[g]),
      .hit_o      (hit[g+1]),
      .acc_o      (acc[g+1])
    );
  end

  always_comb begin
    res_nxt    = '0;
    status_nxt = hit[ENTRIES] ? STAT_OK : STAT_MISS;
    case (op_r)
      ACT_ADD:    status_nxt = vld[ENTRIES-1] ? STAT_FULL : STAT_OK;
      ACT_REMOVE: ;
      ACT_FIND_STA: begin
        res_nxt.sta_ip   = acc[ENTRIES].sta_ip;
        res_nxt.sta_port = acc[ENTRIES].sta_port;
      end
      ACT_FIND_PUB: res_nxt.public_port = acc[ENTRIES].public_port;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.status            = status_r;
  assign out_bus.found_sta_ip      = res_r.sta_ip;
  assign out_bus.found_sta_port    = res_r.sta_port;
  assign out_bus.found_public_port = res_r.public_port;

`ifndef SYNTH
  // Occupied cells always form one run starting at the oldest end.
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld + 1'b1) & vld) == '0)
    else $error("table cells are not packed towards the oldest end");

  a_accept_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_RESOLVE)
    else $error("accepted beat did not move to resolve");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("resolved beat did not reach the output register");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE && !out_free) |=> (state_r == ST_RESOLVE && $stable(op_r)))
    else $error("resolve left while the output register was blocked");
`endif

endmodule

`default_nettype wire
